>>> sv/overwriting_trace_log_buffer_assert.svh
// assertion macros for the trace log buffer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef OVERWRITING_TRACE_LOG_BUFFER_ASSERT_SVH
`define OVERWRITING_TRACE_LOG_BUFFER_ASSERT_SVH

// condition and consequence in the same cycle
`define OTLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define OTLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/otlb_pkg.sv
// shared types and constants for the overwriting trace log buffer
// no dependencies
`default_nettype none

package otlb_pkg;

    localparam int DEPTH_DEF     = 128;
    localparam int MAX_BURST_DEF = 64;

    localparam int PID_W    = 22;
    localparam int MAJOR_W  = 12;
    localparam int MINOR_W  = 20;
    localparam int INODE_W  = 64;
    localparam int OFFSET_W = 63;
    localparam int LENGTH_W = 32;
    localparam int READ_W   = 7;
    localparam int LEFT_W   = 7;
    localparam int OVR_W    = 32;
    localparam int RDR_W    = 16;
    localparam int REQ_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOG    = 2'd0,
        REQ_READ   = 2'd1,
        REQ_ATTACH = 2'd2,
        REQ_DETACH = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed {
        logic [PID_W-1:0]    pid;
        logic [MAJOR_W-1:0]  major;
        logic [MINOR_W-1:0]  minor;
        logic [INODE_W-1:0]  inode;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic log_we;
        logic attach;
        logic detach;
        logic ld_empty;
        logic rd_start;
        logic rd_issue;
        logic rd_load;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic readers_nz;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/overwriting_trace_log_buffer.sv
// Ring log of write-trace records that overwrites the oldest record when full, so at most
// DEPTH-1 records are held; logs with no reader or a zero major are dropped. Log events,
// reader attach and reader detach may arrive back to back. A read of n = min(read_count,
// held, MAX_BURST) records passes the issue step and the registered read of the single
// record ram into the result register, then gives one result per cycle while the output
// side does not stall; no input is taken until the last result is loaded. A read with
// nothing to return gives one empty result in the cycle after the transfer.
// top level, depends on otlb_pkg, otlb_ctrl and otlb_dp
`default_nettype none

module overwriting_trace_log_buffer
    import otlb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [PID_W-1:0]      pid,
    input  wire logic [MAJOR_W-1:0]    major_number,
    input  wire logic [MINOR_W-1:0]    dev_minor,
    input  wire logic [INODE_W-1:0]    inode_number,
    input  wire logic [OFFSET_W-1:0]   file_offset,
    input  wire logic [LENGTH_W-1:0]   write_length,
    input  wire logic [READ_W-1:0]     read_count,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic      [PID_W-1:0]      entry_pid,
    output logic      [MAJOR_W-1:0]    entry_major,
    output logic      [MINOR_W-1:0]    entry_minor,
    output logic      [INODE_W-1:0]    entry_inode,
    output logic      [OFFSET_W-1:0]   entry_offset,
    output logic      [LENGTH_W-1:0]   entry_length,
    output logic                       entry_valid,
    output logic                       last_entry,
    output logic      [OVR_W-1:0]      overrun_total,
    output logic      [LEFT_W-1:0]     entries_left,
    output logic      [RDR_W-1:0]      reader_count
);

    localparam int AW = $clog2(DEPTH);

    cmd_t          cmd;
    status_t       st;
    logic [AW-1:0] held;

    otlb_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req_type     (req_type),
        .major_number (major_number),
        .read_count   (read_count),
        .held         (held),
        .st           (st),
        .cmd          (cmd)
    );

    otlb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .held          (held),
        .pid           (pid),
        .major_number  (major_number),
        .dev_minor     (dev_minor),
        .inode_number  (inode_number),
        .file_offset   (file_offset),
        .write_length  (write_length),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .entry_pid     (entry_pid),
        .entry_major   (entry_major),
        .entry_minor   (entry_minor),
        .entry_inode   (entry_inode),
        .entry_offset  (entry_offset),
        .entry_length  (entry_length),
        .entry_valid   (entry_valid),
        .last_entry    (last_entry),
        .overrun_total (overrun_total),
        .entries_left  (entries_left),
        .reader_count  (reader_count)
    );

endmodule

`default_nettype wire

>>> sv/otlb_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module otlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/otlb_ctrl.sv
// controller for the trace log buffer: request decode and read burst sequencing
// depends on otlb_pkg
`default_nettype none

module otlb_ctrl
    import otlb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic [REQ_W-1:0]         req_type,
    input  wire logic [MAJOR_W-1:0]       major_number,
    input  wire logic [READ_W-1:0]        read_count,
    input  wire logic [$clog2(DEPTH)-1:0] held,
    input  wire status_t                  st,
    output cmd_t                          cmd
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (AW > READ_W) ? AW : READ_W;

    state_t              state_reg;
    state_t              state_next;
    logic [READ_W-1:0]   iss_left_reg;
    logic [READ_W-1:0]   iss_left_next;
    logic [READ_W-1:0]   emit_left_reg;
    logic [READ_W-1:0]   emit_left_next;
    logic                pend_reg;
    logic                pend_next;

    logic                is_read;
    logic                accept;
    logic [CMP_W-1:0]    want_w;
    logic [CMP_W-1:0]    held_w;
    logic [CMP_W-1:0]    n_w;
    logic [READ_W-1:0]   burst;
    logic                load;
    logic                issue;

    assign is_read    = (req_t'(req_type) == REQ_READ);
    assign item_stall = (state_reg != ST_IDLE) || (is_read && !st.out_free);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        want_w = CMP_W'(read_count);
        held_w = CMP_W'(held);
        n_w    = (want_w < held_w) ? want_w : held_w;
        if (n_w > CMP_W'(MAX_BURST))
        begin
            n_w = CMP_W'(MAX_BURST);
        end
        burst = READ_W'(n_w);
    end

    assign load  = (state_reg == ST_DRAIN) && pend_reg && st.out_free;
    assign issue = (state_reg == ST_DRAIN) && (iss_left_reg != '0) && (!pend_reg || load);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_read && (burst != '0))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load && (emit_left_reg == READ_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // burst counters
    always_comb
    begin
        iss_left_next  = iss_left_reg;
        emit_left_next = emit_left_reg;
        pend_next      = pend_reg;
        if (state_reg == ST_IDLE)
        begin
            if (accept && is_read)
            begin
                iss_left_next  = burst;
                emit_left_next = burst;
                pend_next      = 1'b0;
            end
        end
        else
        begin
            if (load)
            begin
                emit_left_next = emit_left_reg - READ_W'(1);
            end
            if (issue)
            begin
                iss_left_next = iss_left_reg - READ_W'(1);
                pend_next     = 1'b1;
            end
            else if (load)
            begin
                pend_next = 1'b0;
            end
        end
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_t'(req_type))
                        REQ_LOG:    cmd.log_we   = st.readers_nz && (major_number != '0);
                        REQ_READ:
                        begin
                            cmd.ld_empty = (burst == '0);
                            cmd.rd_start = (burst != '0);
                        end
                        REQ_ATTACH: cmd.attach   = 1'b1;
                        REQ_DETACH: cmd.detach   = 1'b1;
                        default:    cmd          = '0;
                    endcase
                end
            end
            ST_DRAIN:
            begin
                cmd.rd_issue = issue;
                cmd.rd_load  = load;
                cmd.last     = (emit_left_reg == READ_W'(1));
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_left_reg  <= '0;
            emit_left_reg <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_left_reg  <= iss_left_next;
            emit_left_reg <= emit_left_next;
            pend_reg      <= pend_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/otlb_dp.sv
// datapath for the trace log buffer: ring heads, counters, record ram, result register
// depends on otlb_pkg and otlb_ram
`default_nettype none

module otlb_dp
    import otlb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output status_t                       st,
    output logic      [$clog2(DEPTH)-1:0] held,
    input  wire logic [PID_W-1:0]         pid,
    input  wire logic [MAJOR_W-1:0]       major_number,
    input  wire logic [MINOR_W-1:0]       dev_minor,
    input  wire logic [INODE_W-1:0]       inode_number,
    input  wire logic [OFFSET_W-1:0]      file_offset,
    input  wire logic [LENGTH_W-1:0]      write_length,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic      [PID_W-1:0]         entry_pid,
    output logic      [MAJOR_W-1:0]       entry_major,
    output logic      [MINOR_W-1:0]       entry_minor,
    output logic      [INODE_W-1:0]       entry_inode,
    output logic      [OFFSET_W-1:0]      entry_offset,
    output logic      [LENGTH_W-1:0]      entry_length,
    output logic                          entry_valid,
    output logic                          last_entry,
    output logic      [OVR_W-1:0]         overrun_total,
    output logic      [LEFT_W-1:0]        entries_left,
    output logic      [RDR_W-1:0]         reader_count
);

    localparam int AW = $clog2(DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] h);
        ring_next = (h == AW'(DEPTH - 1)) ? '0 : h + AW'(1);
    endfunction

    function automatic logic [AW-1:0] held_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
        logic [AW:0] wrap;
        wrap    = {1'b0, w} + (AW+1)'(DEPTH) - {1'b0, r};
        held_of = (w >= r) ? (w - r) : wrap[AW-1:0];
    endfunction

    logic [AW-1:0]    wr_head_reg;
    logic [AW-1:0]    wr_head_next;
    logic [AW-1:0]    rd_head_reg;
    logic [AW-1:0]    rd_head_next;
    logic [AW-1:0]    iss_ptr_reg;
    logic [AW-1:0]    iss_ptr_next;
    logic [OVR_W-1:0] overrun_reg;
    logic [OVR_W-1:0] overrun_next;
    logic [RDR_W-1:0] readers_reg;
    logic [RDR_W-1:0] readers_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rec_t             out_rec_reg;
    logic             out_ev_reg;
    logic             out_last_reg;
    logic [OVR_W-1:0] out_ovr_reg;
    logic [LEFT_W-1:0] out_left_reg;
    logic [RDR_W-1:0] out_rdr_reg;

    rec_t             wr_rec;
    rec_t             rd_rec;
    logic [AW-1:0]    wr_inc;
    logic [AW-1:0]    rd_inc;
    logic [AW-1:0]    left_src;
    logic             out_load;

    assign wr_rec = '{pid: pid, major: major_number, minor: dev_minor, inode: inode_number,
                      offset: file_offset, length: write_length};

    otlb_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.log_we),
        .waddr (wr_head_reg),
        .wdata (wr_rec),
        .re    (cmd.rd_issue),
        .raddr (iss_ptr_reg),
        .rdata (rd_rec)
    );

    assign wr_inc = ring_next(wr_head_reg);
    assign rd_inc = ring_next(rd_head_reg);
    assign held   = held_of(wr_head_reg, rd_head_reg);

    assign st.readers_nz = (readers_reg != '0);
    assign st.out_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        wr_head_next = wr_head_reg;
        rd_head_next = rd_head_reg;
        overrun_next = overrun_reg;
        readers_next = readers_reg;
        iss_ptr_next = iss_ptr_reg;
        if (cmd.log_we)
        begin
            wr_head_next = wr_inc;
            if (wr_inc == rd_head_reg)
            begin
                rd_head_next = rd_inc;
                overrun_next = overrun_reg + OVR_W'(1);
            end
        end
        if (cmd.attach && (readers_reg != '1))
        begin
            readers_next = readers_reg + RDR_W'(1);
        end
        if (cmd.detach && (readers_reg != '0))
        begin
            readers_next = readers_reg - RDR_W'(1);
        end
        if (cmd.rd_start)
        begin
            iss_ptr_next = rd_head_reg;
        end
        else if (cmd.rd_issue)
        begin
            iss_ptr_next = ring_next(iss_ptr_reg);
        end
        if (cmd.rd_load)
        begin
            rd_head_next = rd_inc;
        end
    end

    assign out_load       = cmd.rd_load || cmd.ld_empty;
    assign left_src       = held_of(wr_head_reg, cmd.rd_load ? rd_inc : rd_head_reg);
    assign out_valid_next = out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_head_reg   <= '0;
            rd_head_reg   <= '0;
            iss_ptr_reg   <= '0;
            overrun_reg   <= '0;
            readers_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_head_reg   <= wr_head_next;
            rd_head_reg   <= rd_head_next;
            iss_ptr_reg   <= iss_ptr_next;
            overrun_reg   <= overrun_next;
            readers_reg   <= readers_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rec_reg  <= cmd.rd_load ? rd_rec : '0;
            out_ev_reg   <= cmd.rd_load;
            out_last_reg <= cmd.rd_load ? cmd.last : 1'b1;
            out_ovr_reg  <= overrun_reg;
            out_left_reg <= LEFT_W'(left_src);
            out_rdr_reg  <= readers_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign entry_pid     = out_rec_reg.pid;
    assign entry_major   = out_rec_reg.major;
    assign entry_minor   = out_rec_reg.minor;
    assign entry_inode   = out_rec_reg.inode;
    assign entry_offset  = out_rec_reg.offset;
    assign entry_length  = out_rec_reg.length;
    assign entry_valid   = out_ev_reg;
    assign last_entry    = out_last_reg;
    assign overrun_total = out_ovr_reg;
    assign entries_left  = out_left_reg;
    assign reader_count  = out_rdr_reg;

endmodule

`default_nettype wire

>>> sv/otlb_checker.sv
// port-level checks for the trace log buffer, bound to the top level
// depends on otlb_pkg and overwriting_trace_log_buffer_assert.svh
`default_nettype none

`include "overwriting_trace_log_buffer_assert.svh"

module otlb_checker
    import otlb_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_stall,
    input wire logic                result_valid,
    input wire logic                result_stall,
    input wire logic [PID_W-1:0]    entry_pid,
    input wire logic [INODE_W-1:0]  entry_inode,
    input wire logic [LENGTH_W-1:0] entry_length,
    input wire logic                entry_valid,
    input wire logic                last_entry,
    input wire logic [LEFT_W-1:0]   entries_left
);

    // stalled result keeps its payload
    `OTLB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(entry_pid) && $stable(entries_left) && $stable(last_entry), "stalled result changed")

    // empty read result carries no record and closes the read
    `OTLB_ASSERT_NOW(a_empty_shape, result_valid && !entry_valid, last_entry && (entry_pid == '0) && (entry_inode == '0) && (entry_length == '0), "malformed empty result")

    // only a real record can be followed by more results
    `OTLB_ASSERT_NOW(a_mid_valid, result_valid && !last_entry, entry_valid, "non-last result without record")

    // while a burst is still open no new input transfer is taken
    `OTLB_ASSERT_NOW(a_mid_blocks, result_valid && !last_entry, item_stall, "input open during burst")

endmodule

bind overwriting_trace_log_buffer otlb_checker u_checker (.*);

`default_nettype wire

>>> bench/tb_overwriting_trace_log_buffer.sv
// testbench for overwriting_trace_log_buffer: a queue-fed driver and a checking monitor around a
// ring-log predictor with random idling on both sides and a long result hold-off
// depends on otlb_pkg and the overwriting_trace_log_buffer rtl
module tb_overwriting_trace_log_buffer;
    import otlb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 16;
    localparam int PHASE_LEN      = 62;

    typedef struct packed {
        req_t              kind;
        rec_t              rec;
        logic [READ_W-1:0] count;
        logic [1:0]        phase;
        logic              drain_first;
        logic              hold_mark;
    } trace_req_t;

    typedef struct packed {
        rec_t              rec;
        logic              valid;
        logic              last;
        logic [OVR_W-1:0]  overrun;
        logic [LEFT_W-1:0] left;
        logic [RDR_W-1:0]  readers;
    } trace_entry_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [REQ_W-1:0]    req_type = '0;
    logic [PID_W-1:0]    pid = '0;
    logic [MAJOR_W-1:0]  major_number = '0;
    logic [MINOR_W-1:0]  dev_minor = '0;
    logic [INODE_W-1:0]  inode_number = '0;
    logic [OFFSET_W-1:0] file_offset = '0;
    logic [LENGTH_W-1:0] write_length = '0;
    logic [READ_W-1:0]   read_count = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [PID_W-1:0]    entry_pid;
    logic [MAJOR_W-1:0]  entry_major;
    logic [MINOR_W-1:0]  entry_minor;
    logic [INODE_W-1:0]  entry_inode;
    logic [OFFSET_W-1:0] entry_offset;
    logic [LENGTH_W-1:0] entry_length;
    logic                entry_valid;
    logic                last_entry;
    logic [OVR_W-1:0]    overrun_total;
    logic [LEFT_W-1:0]   entries_left;
    logic [RDR_W-1:0]    reader_count;

    trace_req_t   pending_requests[$];
    trace_entry_t expected_entries[$];

    rec_t             ring[DEPTH_DEF];
    int               ring_rd = 0;
    int               ring_wr = 0;
    logic [OVR_W-1:0] drop_count = '0;
    logic [RDR_W-1:0] attached = '0;

    int         send_idle_pct[4] = '{18, 54, 0, 0};
    int         recv_idle_pct[4] = '{54, 18, 0, 0};
    logic [1:0] idle_phase = 2'd0;
    int         gen_readers = 0;
    logic       item_taken = 1'b0;
    logic       cur_hold = 1'b0;
    int         hold_trig = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         mismatches = 0;

    overwriting_trace_log_buffer dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rec_t rand_rec();
        rec_t r;
        r.pid    = PID_W'($urandom);
        r.major  = MAJOR_W'($urandom_range(1, 4095));
        r.minor  = MINOR_W'($urandom);
        r.inode  = {$urandom, $urandom};
        r.offset = OFFSET_W'({$urandom, $urandom});
        r.length = $urandom;
        case ($urandom_range(0, 19))
            0: r = '1;
            1:
            begin
                r = '0;
                r.major = MAJOR_W'(1);
            end
            2: r.major = '0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_item(input req_t kind, input rec_t r, input int cnt, input bit drain,
                             input bit hold);
        trace_req_t t;
        t.kind        = kind;
        t.rec         = r;
        t.count       = READ_W'(cnt);
        t.phase       = (pending_requests.size() < PHASE_LEN) ? 2'd0 :
                        (pending_requests.size() < 2 * PHASE_LEN) ? 2'd1 : 2'd2;
        t.drain_first = drain;
        t.hold_mark   = hold;
        if (kind == REQ_ATTACH && gen_readers < 65535)
            gen_readers++;
        if (kind == REQ_DETACH && gen_readers > 0)
            gen_readers--;
        pending_requests.push_back(t);
    endtask

    task automatic apply_request();
        trace_entry_t e;
        int held;
        int want;
        case (req_t'(req_type))
            REQ_LOG:
            if (attached != 0 && major_number != 0)
            begin
                ring[ring_wr] = {pid, major_number, dev_minor, inode_number, file_offset,
                                 write_length};
                ring_wr = (ring_wr + 1) % DEPTH_DEF;
                if (ring_wr == ring_rd)
                begin
                    ring_rd = (ring_rd + 1) % DEPTH_DEF;
                    drop_count++;
                end
            end
            REQ_ATTACH:
            if (attached != '1)
                attached++;
            REQ_DETACH:
            if (attached != 0)
                attached--;
            default:
            begin
                held = (ring_wr + DEPTH_DEF - ring_rd) % DEPTH_DEF;
                want = read_count;
                if (want > held)
                    want = held;
                if (want > MAX_BURST_DEF)
                    want = MAX_BURST_DEF;
                if (want == 0)
                begin
                    e = '0;
                    e.last    = 1'b1;
                    e.overrun = drop_count;
                    e.left    = LEFT_W'(held);
                    e.readers = attached;
                    expected_entries.push_back(e);
                end
                for (int k = 0; k < want; k++)
                begin
                    e.rec     = ring[ring_rd];
                    e.valid   = 1'b1;
                    e.last    = (k == want - 1);
                    ring_rd   = (ring_rd + 1) % DEPTH_DEF;
                    e.overrun = drop_count;
                    e.left    = LEFT_W'((ring_wr + DEPTH_DEF - ring_rd) % DEPTH_DEF);
                    e.readers = attached;
                    expected_entries.push_back(e);
                end
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // input transfers feed the predictor, result transfers are checked in order
    always @(posedge clk)
    begin : monitor
        trace_entry_t e;
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                item_taken = 1'b1;
                apply_request();
                if (cur_hold)
                    hold_trig++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_entries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0t mismatch: expected no result, actual pid %h valid %b",
                                 $time, entry_pid, entry_valid);
                end
                else
                begin
                    e = expected_entries.pop_front();
                    check_field("entry_pid", e.rec.pid, entry_pid);
                    check_field("entry_major", e.rec.major, entry_major);
                    check_field("entry_minor", e.rec.minor, entry_minor);
                    check_field("entry_inode", e.rec.inode, entry_inode);
                    check_field("entry_offset", e.rec.offset, entry_offset);
                    check_field("entry_length", e.rec.length, entry_length);
                    check_field("entry_valid", e.valid, entry_valid);
                    check_field("last_entry", e.last, last_entry);
                    check_field("overrun_total", e.overrun, overrun_total);
                    check_field("entries_left", e.left, entries_left);
                    check_field("reader_count", e.readers, reader_count);
                end
            end
            if (item_taken || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_overwriting_trace_log_buffer failed");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        trace_req_t nxt;
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pending_requests.size() != 0
                && !(pending_requests[0].drain_first && expected_entries.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct[pending_requests[0].phase])
            begin
                nxt = pending_requests.pop_front();
                item_valid   <= 1'b1;
                req_type     <= nxt.kind;
                pid          <= nxt.rec.pid;
                major_number <= nxt.rec.major;
                dev_minor    <= nxt.rec.minor;
                inode_number <= nxt.rec.inode;
                file_offset  <= nxt.rec.offset;
                write_length <= nxt.rec.length;
                read_count   <= nxt.count;
                cur_hold     <= nxt.hold_mark;
                idle_phase   <= nxt.phase;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result side stall, with a long hold-off after a marked transfer
    always @(negedge clk)
    begin
        if (hold_seen != hold_trig)
        begin
            hold_seen = hold_trig;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct[idle_phase]);
    end

    initial
    begin
        int n;
        int cnt;
        int burst;
        rec_t r;

        // directed: ignored logs, empty reads, detach at zero, extreme records, clamped reads
        push_item(REQ_LOG, rand_rec(), 0, 0, 0);
        push_item(REQ_READ, rand_rec(), 5, 0, 0);
        push_item(REQ_DETACH, rand_rec(), 0, 0, 0);
        push_item(REQ_ATTACH, rand_rec(), 0, 0, 0);
        r = rand_rec();
        r.major = '0;
        push_item(REQ_LOG, r, 0, 0, 0);
        push_item(REQ_LOG, '1, 0, 0, 0);
        r = '0;
        r.major = MAJOR_W'(1);
        push_item(REQ_LOG, r, 0, 0, 0);
        push_item(REQ_READ, rand_rec(), 0, 0, 0);
        push_item(REQ_READ, '1, 64, 0, 0);
        for (int i = 0; i < 3; i++)
            push_item(REQ_LOG, rand_rec(), 0, 0, 0);
        push_item(REQ_READ, rand_rec(), 1, 0, 0);
        push_item(REQ_ATTACH, rand_rec(), 0, 0, 0);
        push_item(REQ_DETACH, rand_rec(), 0, 0, 0);
        push_item(REQ_READ, rand_rec(), 64, 0, 0);
        push_item(REQ_READ, rand_rec(), 3, 0, 0);

        // overfill the ring, then read while the result side holds off
        for (int i = 0; i < 130; i++)
        begin
            r = rand_rec();
            if (r.major == '0)
                r.major = MAJOR_W'(7);
            push_item(REQ_LOG, r, 0, 0, 0);
        end
        push_item(REQ_READ, rand_rec(), 64, 0, 1);
        for (int i = 0; i < 12; i++)
            if (i % 4 == 3)
                push_item(REQ_READ, rand_rec(), $urandom_range(0, 20), 0, 0);
            else
                push_item(REQ_LOG, rand_rec(), 0, 0, 0);
        push_item(REQ_READ, rand_rec(), 64, 1, 0);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            cnt = $urandom_range(0, 99);
            if (cnt < 8)
            begin
                burst = $urandom_range(4, 10);
                for (int i = 0; i < burst; i++)
                    push_item(REQ_LOG, rand_rec(), 0, 0, 0);
                n += burst;
            end
            else
            begin
                if (cnt < 55)
                    push_item(REQ_LOG, rand_rec(), 0, 0, 0);
                else if (cnt < 80)
                begin
                    case ($urandom_range(0, 9))
                        0: cnt = 64;
                        1, 2: cnt = $urandom_range(13, 64);
                        default: cnt = $urandom_range(0, 12);
                    endcase
                    push_item(REQ_READ, rand_rec(), cnt, $urandom_range(0, 19) == 0, 0);
                end
                else if (cnt < 90 || (gen_readers <= 1 && $urandom_range(0, 3) != 0))
                    push_item(REQ_ATTACH, rand_rec(), 0, 0, 0);
                else
                    push_item(REQ_DETACH, rand_rec(), 0, 0, 0);
                n++;
            end
        end

        push_item(REQ_READ, rand_rec(), $urandom_range(0, 64), 0, 0);
        push_item(REQ_DETACH, rand_rec(), 0, 0, 0);
        push_item(REQ_READ, rand_rec(), 0, 0, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_requests.size() != 0 || item_valid || expected_entries.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("tb_overwriting_trace_log_buffer passed");
        else
            $display("tb_overwriting_trace_log_buffer failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/otlb_pkg.sv
sv/otlb_ram.sv
sv/otlb_ctrl.sv
sv/otlb_dp.sv
sv/overwriting_trace_log_buffer.sv
sv/otlb_checker.sv
bench/tb_overwriting_trace_log_buffer.sv
